// ----- design/six_bit_symbol_codec_core_defines.svh -----
// Assertion macros shared by the six-bit symbol codec RTL.
// Depends on nothing; every user must have clk and rst_n in scope.
`ifndef SIX_BIT_SYMBOL_CODEC_CORE_DEFINES_SVH
`define SIX_BIT_SYMBOL_CODEC_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/scb_pkg.sv -----
// Shared types, constants and alphabet functions of the six-bit symbol codec.
// No dependencies; imported by every module of the block.
package scb_pkg;

  localparam int ACC_W      = 24;
  localparam int HELD_W     = 5;
  localparam int CFG_ADDR_W = 3;

  // Register index carried in paddr[2].
  localparam logic REG_MODE = 1'b0;

  // Direction codes of the mode register.
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // Character 0 of the alphabet sits in the most significant byte.
  localparam logic [8*64-1:0] ALPHABET =
    "abcdefghijkmnopqrstuvwxyzABCDEFGHJKLMNPQRSTUVWXYZ23456789-+*/$%&";

  typedef struct packed {
    logic [7:0] value;
    logic [3:0] checksum;
  } scb_in_t;

  typedef struct packed {
    logic [7:0] result_value;
    logic       is_checksum;
    logic       last;
    logic       error;
  } scb_out_t;

  typedef enum logic [1:0] {
    KIND_ENC      = 2'd0,
    KIND_DEC_SYM  = 2'd1,
    KIND_DEC_ERR  = 2'd2,
    KIND_DEC_SKIP = 2'd3
  } scb_kind_t;

  // One classified word on its way from the front end to the back end.
  typedef struct packed {
    scb_kind_t   kind;
    logic        is_final;
    logic [11:0] bits;
  } scb_entry_t;

  function automatic logic [7:0] alpha_char(input logic [5:0] idx);
    return ALPHABET[8*(63-int'(idx)) +: 8];
  endfunction

  // Returns {hit, symbol}; the characters are unique, so the matches are ORed.
  function automatic logic [6:0] sym_lookup(input logic [7:0] ch);
    logic       hit;
    logic [5:0] idx;
    hit = 1'b0;
    idx = '0;
    for (int i = 0; i < 64; i++) begin
      if (ALPHABET[8*(63-i) +: 8] == ch) begin
        hit = 1'b1;
        idx = idx | 6'(i);
      end
    end
    return {hit, idx};
  endfunction

endpackage

// ----- design/scb_fifo.sv -----
// Small register queue between the front end and the back end.
// Depends on scb_pkg for the entry type and on the assertion macro header.
`include "six_bit_symbol_codec_core_defines.svh"

module scb_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  scb_pkg::scb_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                pop_valid,
  output scb_pkg::scb_entry_t pop_entry
);
  import scb_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  scb_entry_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  `SCB_ASSERT_NEXT(a_fifo_fill, push && !pop, count_r == $past(count_r) + 1'b1, "queue fill count did not rise on a lone push")

endmodule

// ----- design/scb_front.sv -----
// Front end: takes input words, tracks the barcode position and classifies each word.
// Depends on scb_pkg for types and the alphabet lookup, and on the assertion macros.
`include "six_bit_symbol_codec_core_defines.svh"

module scb_front #(
  parameter int DATA_BYTES    = 8,
  parameter int CHECKSUM_BITS = 4,
  parameter int SYMBOL_COUNT  = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                mode,
  input  logic                cfg_clear,
  input  logic                in_valid,
  input  scb_pkg::scb_in_t    in_data,
  output logic                in_ready,
  input  logic                fifo_full,
  output logic                push,
  output scb_pkg::scb_entry_t push_entry
);
  import scb_pkg::*;

  localparam int MAX_N = (DATA_BYTES > SYMBOL_COUNT) ? DATA_BYTES : SYMBOL_COUNT;
  localparam int CNT_W = $clog2(MAX_N + 1);
  localparam logic [3:0] CHK_MASK = 4'((1 << CHECKSUM_BITS) - 1);

  logic [CNT_W-1:0] item_count_r, item_count_nxt;
  logic             discarding_r, discarding_nxt;
  logic             is_final;
  logic [6:0]       lookup;

  assign in_ready = !fifo_full;
  assign push     = in_valid && in_ready;
  assign lookup   = sym_lookup(in_data.value);
  assign is_final = (mode == MODE_DECODE) ? (item_count_r >= CNT_W'(SYMBOL_COUNT - 1))
                                          : (item_count_r >= CNT_W'(DATA_BYTES - 1));

  always_comb begin
    push_entry.is_final = is_final;
    push_entry.bits     = '0;
    if (mode == MODE_ENCODE) begin
      push_entry.kind = KIND_ENC;
      push_entry.bits = {(is_final ? (in_data.checksum & CHK_MASK) : 4'd0), in_data.value};
    end else if (discarding_r) begin
      push_entry.kind = KIND_DEC_SKIP;
    end else if (!lookup[6]) begin
      push_entry.kind = KIND_DEC_ERR;
    end else begin
      push_entry.kind = KIND_DEC_SYM;
      push_entry.bits = {6'd0, lookup[5:0]};
    end
  end

  always_comb begin
    item_count_nxt = item_count_r;
    discarding_nxt = discarding_r;
    if (cfg_clear) begin
      item_count_nxt = '0;
      discarding_nxt = 1'b0;
    end else if (push) begin
      if (is_final) begin
        item_count_nxt = '0;
        discarding_nxt = 1'b0;
      end else begin
        item_count_nxt = item_count_r + 1'b1;
        if (push_entry.kind == KIND_DEC_ERR) begin
          discarding_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_count_r <= '0;
      discarding_r <= 1'b0;
    end else begin
      item_count_r <= item_count_nxt;
      discarding_r <= discarding_nxt;
    end
  end

  `SCB_ASSERT_NOW(a_front_discard_mode, mode == MODE_ENCODE, !discarding_r, "discarding set while encoding")
  `SCB_ASSERT_NEXT(a_front_final_wrap, push && is_final, item_count_r == '0, "position not cleared after the final word")

endmodule

// ----- design/scb_back.sv -----
// Back end: holds the bit accumulator and emits one result word per cycle unless out_ready stalls it.
// Depends on scb_pkg for types and the alphabet table, and on the assertion macros.
`include "six_bit_symbol_codec_core_defines.svh"

module scb_back #(
  parameter int DATA_BYTES    = 8,
  parameter int CHECKSUM_BITS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_clear,
  input  logic                pop_valid,
  input  scb_pkg::scb_entry_t pop_entry,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output scb_pkg::scb_out_t   out_data
);
  import scb_pkg::*;

  localparam int BOUT_W = $clog2(DATA_BYTES + 1);
  localparam logic [7:0] CMASK = 8'((1 << CHECKSUM_BITS) - 1);

  typedef struct packed {
    logic [ACC_W-1:0]  acc;
    logic [HELD_W-1:0] held;
    logic [BOUT_W-1:0] bout;
    logic              tail;
  } work_t;

  work_t     work_r, work_nxt;
  logic      cur_vld_r, cur_vld_nxt;
  scb_kind_t cur_kind_r, cur_kind_nxt;
  logic      cur_final_r, cur_final_nxt;
  logic      out_valid_r, out_valid_nxt;
  scb_out_t  out_data_r, out_data_nxt;

  work_t    w_e, w_f;
  scb_out_t res;
  logic     slot_free, pend_pre, pend_post, emit, finish;

  function automatic logic pending(input work_t w, input scb_kind_t k, input logic fin);
    logic p;
    case (k)
      KIND_ENC:     p = (w.held >= HELD_W'(6)) || (fin && (w.held != '0));
      KIND_DEC_SYM: p = ((w.held >= HELD_W'(8)) && (w.bout < BOUT_W'(DATA_BYTES))) || w.tail;
      KIND_DEC_ERR: p = w.tail;
      default:      p = 1'b0;
    endcase
    return p;
  endfunction

  assign slot_free = !out_valid_r || out_ready;
  assign pend_pre  = cur_vld_r && pending(work_r, cur_kind_r, cur_final_r);
  assign emit      = pend_pre && slot_free;

  // Result of the current word and the accumulator left behind by it.
  always_comb begin
    w_e = work_r;
    res = '0;
    if (emit) begin
      case (cur_kind_r)
        KIND_ENC: begin
          res.result_value = alpha_char(work_r.acc[5:0]);
          w_e.acc = work_r.acc >> 6;
          if (work_r.held >= HELD_W'(6)) begin
            res.last = cur_final_r && (work_r.held == HELD_W'(6));
            w_e.held = work_r.held - HELD_W'(6);
          end else begin
            res.last = 1'b1;
            w_e.held = '0;
          end
        end
        KIND_DEC_SYM: begin
          if ((work_r.held >= HELD_W'(8)) && (work_r.bout < BOUT_W'(DATA_BYTES))) begin
            res.result_value = work_r.acc[7:0];
            w_e.acc  = work_r.acc >> 8;
            w_e.held = work_r.held - HELD_W'(8);
            w_e.bout = work_r.bout + 1'b1;
          end else begin
            res.result_value = work_r.acc[7:0] & CMASK;
            res.is_checksum  = 1'b1;
            res.last         = 1'b1;
            w_e.tail         = 1'b0;
          end
        end
        KIND_DEC_ERR: begin
          res.last  = 1'b1;
          res.error = 1'b1;
          w_e.tail  = 1'b0;
        end
        default: begin
          w_e = work_r;
        end
      endcase
    end
  end

  assign pend_post = cur_vld_r && pending(w_e, cur_kind_r, cur_final_r);
  assign finish    = cur_vld_r && !pend_post;
  assign w_f       = (finish && cur_final_r) ? work_t'('0) : w_e;
  assign pop       = !pend_post && pop_valid;

  // The next word merges into the accumulator in the cycle its predecessor ends.
  always_comb begin
    work_nxt      = w_f;
    cur_vld_nxt   = finish ? 1'b0 : cur_vld_r;
    cur_kind_nxt  = cur_kind_r;
    cur_final_nxt = cur_final_r;
    if (pop) begin
      cur_vld_nxt   = 1'b1;
      cur_kind_nxt  = pop_entry.kind;
      cur_final_nxt = pop_entry.is_final;
      case (pop_entry.kind)
        KIND_ENC: begin
          work_nxt.acc  = w_f.acc | (ACC_W'(pop_entry.bits) << w_f.held);
          work_nxt.held = w_f.held + (pop_entry.is_final ? HELD_W'(8 + CHECKSUM_BITS)
                                                         : HELD_W'(8));
          work_nxt.tail = 1'b0;
        end
        KIND_DEC_SYM: begin
          if (w_f.held <= HELD_W'(18)) begin
            work_nxt.acc  = w_f.acc | (ACC_W'(pop_entry.bits[5:0]) << w_f.held);
            work_nxt.held = w_f.held + HELD_W'(6);
          end
          work_nxt.tail = pop_entry.is_final;
        end
        KIND_DEC_ERR: begin
          work_nxt.tail = 1'b1;
        end
        default: begin
          work_nxt.tail = 1'b0;
        end
      endcase
    end
    if (cfg_clear) begin
      work_nxt = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_r      <= '0;
      cur_vld_r   <= 1'b0;
      cur_kind_r  <= KIND_ENC;
      cur_final_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      work_r      <= work_nxt;
      cur_vld_r   <= cur_vld_nxt;
      cur_kind_r  <= cur_kind_nxt;
      cur_final_r <= cur_final_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SCB_ASSERT_NEXT(a_back_err_word, emit && (cur_kind_r == KIND_DEC_ERR), out_valid_r && out_data_r.error && out_data_r.last, "error word not presented as a final error result")
  `SCB_ASSERT_NOW(a_back_enc_leftover, pop && (pop_entry.kind == KIND_ENC), w_f.held < HELD_W'(6), "full symbol left behind before the next byte")

endmodule

// ----- design/six_bit_symbol_codec_core.sv -----
// Top level of the six-bit symbol codec: configuration register and module wiring.
// Depends on scb_pkg, scb_front, scb_fifo and scb_back.
//
//   Channel   Direction  Handshake               Word
//   in_*      sink       in_valid / in_ready     scb_in_t  (value, checksum)
//   out_*     source     out_valid / out_ready   scb_out_t (result_value, is_checksum,
//                                                           last, error)
//   APB       slave      psel, penable, pready   32-bit register, mode at offset 0
//
// The back end emits one result word at a time and holds each word until all of its
// results are out: an encoded byte other than the last yields 1 or 2 symbols, the
// final byte 2 or 3; a decoded character yields at most one byte, the final one also
// a checksum word, and a foreign character an error word instead.
// The front end accepts a word every cycle while the four-entry queue has room.
// Reset is synchronous and active low; it clears the queue, the barcode position
// and the accumulator and selects encoding. There is no clearing pass.
// A stall on out_ready holds the back end; the front end keeps filling the queue.
module six_bit_symbol_codec_core #(
  parameter int DATA_BYTES    = 8,
  parameter int CHECKSUM_BITS = 4,
  parameter int SYMBOL_COUNT  = 12,
  parameter int QUEUE_DEPTH   = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  scb_pkg::scb_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output scb_pkg::scb_out_t                   out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [scb_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import scb_pkg::*;

  logic       mode_r, mode_nxt;
  logic       mode_write;
  logic       fifo_full, push, pop, pop_valid;
  scb_entry_t push_entry, pop_entry;

  // The register file is a single bit; pready never stalls the bus.
  assign pready     = 1'b1;
  assign mode_write = psel && penable && pwrite && (paddr[2] == REG_MODE);
  assign prdata     = (paddr[2] == REG_MODE) ? {31'd0, mode_r} : 32'd0;

  // Every write of mode restarts the barcode in both halves of the datapath.
  always_comb begin
    mode_nxt = mode_r;
    if (mode_write) begin
      mode_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ENCODE;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  scb_front #(
    .DATA_BYTES    (DATA_BYTES),
    .CHECKSUM_BITS (CHECKSUM_BITS),
    .SYMBOL_COUNT  (SYMBOL_COUNT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .mode       (mode_r),
    .cfg_clear  (mode_write),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_ready   (in_ready),
    .fifo_full  (fifo_full),
    .push       (push),
    .push_entry (push_entry)
  );

  scb_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (fifo_full),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry)
  );

  scb_back #(
    .DATA_BYTES    (DATA_BYTES),
    .CHECKSUM_BITS (CHECKSUM_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_clear (mode_write),
    .pop_valid (pop_valid),
    .pop_entry (pop_entry),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- dv/six_bit_symbol_codec_core_test.sv -----
// Self-checking testbench of six_bit_symbol_codec_core: directed and random barcodes
// in both directions, checked word by word against a predictor kept in this file.
// Depends on scb_pkg and the RTL of the codec; needs nothing else.
`timescale 1ns / 100ps

module six_bit_symbol_codec_core_test;
  import scb_pkg::*;

  localparam int DATA_BYTES    = 8;
  localparam int CHECKSUM_BITS = 4;
  localparam int SYMBOL_COUNT  = 12;
  localparam int CHK_MASK      = (1 << CHECKSUM_BITS) - 1;

  // The mode register is register 0, so it sits at byte offset 0.
  localparam logic [CFG_ADDR_W-1:0] MODE_ADDR = {REG_MODE, 2'b00};

  // Characters that are not in the alphabet.
  localparam logic [7:0] NUL_CHAR        = 8'h00;
  localparam logic [7:0] CHAR_NOT_IN_SET = "l";

  // Cycles to let pass after the last expected word before touching the register,
  // since a word that is being discarded leaves nothing behind to wait for.
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT   = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic     in_valid = 1'b0;
  logic     in_ready;
  scb_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  scb_out_t out_data;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  six_bit_symbol_codec_core #(
    .DATA_BYTES   (DATA_BYTES),
    .CHECKSUM_BITS(CHECKSUM_BITS),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk = ~clk;

  // Predictor state: a private copy of the direction and of the barcode position.
  logic        pred_mode;
  logic [23:0] pred_acc;
  int          pred_held;
  int          pred_count;
  int          pred_bytes_out;
  bit          pred_discard;

  logic [7:0] glyphs [64];   // alphabet, character 0 first
  scb_out_t   codec_words_due [$];

  int  mismatches = 0;
  int  cycle_count = 0;
  int  stall_left = 0;
  bit  calm = 1'b0;          // when set, neither side idles
  scb_out_t due_word;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int glyph_index(logic [7:0] ch);
    for (int i = 0; i < 64; i++) begin
      if (glyphs[i] == ch) return i;
    end
    return -1;
  endfunction

  function automatic void push_word(logic [7:0] v, logic chk, logic lst, logic err);
    scb_out_t w;
    w.result_value = v;
    w.is_checksum  = chk;
    w.last         = lst;
    w.error        = err;
    codec_words_due.push_back(w);
  endfunction

  function automatic void clear_position();
    pred_acc       = '0;
    pred_held      = 0;
    pred_count     = 0;
    pred_bytes_out = 0;
    pred_discard   = 1'b0;
  endfunction

  function automatic void set_direction(logic dir);
    pred_mode = dir;
    clear_position();
  endfunction

  function automatic void predict_encode(logic [7:0] b, logic [3:0] chk);
    logic [31:0] acc;
    bit          fin;
    fin = (pred_count + 1 >= DATA_BYTES);
    acc = {8'h00, pred_acc} | (32'(b) << pred_held);
    pred_held += 8;
    if (fin) begin
      acc |= (32'(chk) & CHK_MASK) << pred_held;
      pred_held += CHECKSUM_BITS;
    end
    acc &= 32'hFF_FFFF;
    // Every complete symbol goes out; on the final byte the last one ends the barcode.
    while (pred_held >= 6) begin
      push_word(glyphs[acc[5:0]], 1'b0, fin && (pred_held == 6), 1'b0);
      acc >>= 6;
      pred_held -= 6;
    end
    if (fin) begin
      // The partial symbol is padded with zeros, which the shift has already done.
      if (pred_held > 0) push_word(glyphs[acc[5:0]], 1'b0, 1'b1, 1'b0);
      clear_position();
    end else begin
      pred_acc = acc[23:0];
      pred_count++;
    end
  endfunction

  function automatic void predict_decode(logic [7:0] ch);
    logic [31:0] acc;
    bit          fin;
    int          sym;
    fin = (pred_count + 1 >= SYMBOL_COUNT);
    acc = {8'h00, pred_acc};
    if (!pred_discard) begin
      sym = glyph_index(ch);
      if (sym < 0) begin
        push_word(8'h00, 1'b0, 1'b1, 1'b1);
        pred_discard = 1'b1;
      end else begin
        // A symbol that would overflow the accumulator is counted but dropped.
        if (pred_held <= 18) begin
          acc = (acc | (32'(sym) << pred_held)) & 32'hFF_FFFF;
          pred_held += 6;
        end
        while (pred_held >= 8 && pred_bytes_out < DATA_BYTES) begin
          push_word(acc[7:0], 1'b0, 1'b0, 1'b0);
          acc >>= 8;
          pred_held -= 8;
          pred_bytes_out++;
        end
        // Checksum bits that are missing read as zero, which the mask gives.
        if (fin) push_word(acc[7:0] & 8'(CHK_MASK), 1'b1, 1'b1, 1'b0);
      end
    end
    pred_acc = acc[23:0];
    if (fin) clear_position();
    else pred_count++;
  endfunction

  function automatic void predict_codec_words(scb_in_t w);
    if (pred_mode == MODE_ENCODE) predict_encode(w.value, w.checksum);
    else predict_decode(w.value);
  endfunction

  // ---------------------------------------------------------------------------
  // Driving and checking
  // ---------------------------------------------------------------------------

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_foreign_char();
    case ($urandom_range(0, 3))
      0: return NUL_CHAR;
      1: return CHAR_NOT_IN_SET;
      2: return 8'($urandom_range(128, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offers one word and returns at the edge at which it is taken. Valid is only
  // lowered when a gap follows, so a back-to-back word keeps it high throughout.
  task automatic send_word(logic [7:0] v, logic [3:0] c);
    int      gap;
    scb_in_t w;
    gap = calm ? 0 : pick_gap();
    w.value    = v;
    w.checksum = c;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    predict_codec_words(w);
  endtask

  // Stops sending and waits until every expected word has come out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (codec_words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One APB write; an idle bus cycle follows so that transfers never abut.
  task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == MODE_ADDR) set_direction(data[0]);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_read_check(logic [CFG_ADDR_W-1:0] addr, logic [31:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $display("%0t: register read at %0d: expected %h, actual %h", $time, addr, want,
               prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(logic dir);
    wait_idle();
    cfg_write(MODE_ADDR, {31'b0, dir});
  endtask

  task automatic send_byte_barcode();
    for (int i = 0; i < DATA_BYTES; i++) begin
      send_word(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
    end
  endtask

  // Mostly well-formed text; some barcodes carry one foreign character at a random
  // place, the final one included, and a few are pure noise.
  task automatic send_text_barcode();
    int         r;
    int         flaw_at;
    logic [7:0] ch;
    r = $urandom_range(0, 9);
    flaw_at = (r >= 7 && r <= 8) ? $urandom_range(0, SYMBOL_COUNT - 1) : -1;
    for (int i = 0; i < SYMBOL_COUNT; i++) begin
      if (r == 9) ch = 8'($urandom_range(0, 255));
      else if (i == flaw_at) ch = pick_foreign_char();
      else ch = glyphs[$urandom_range(0, 63)];
      send_word(ch, 4'($urandom_range(0, 15)));
    end
  endtask

  // The receiver stalls at random unless the calm flag is set.
  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // Each word taken from the result channel is held against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (codec_words_due.size() == 0) begin
        $display("%0t: result word with none expected: actual %p", $time, out_data);
        mismatches++;
      end else begin
        due_word = codec_words_due.pop_front();
        if (out_data.result_value !== due_word.result_value ||
            out_data.is_checksum !== due_word.is_checksum ||
            out_data.last !== due_word.last ||
            out_data.error !== due_word.error) begin
          $display("%0t: result word: expected %p, actual %p", $time, due_word, out_data);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d words outstanding", $time,
               codec_words_due.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Both values of the direction register are written and read back.
  task automatic test_mode_register();
    cfg_write(MODE_ADDR, {31'b0, MODE_DECODE});
    cfg_read_check(MODE_ADDR, {31'b0, MODE_DECODE});
    cfg_write(MODE_ADDR, {31'b0, MODE_ENCODE});
    cfg_read_check(MODE_ADDR, {31'b0, MODE_ENCODE});
  endtask

  // All-zero and all-one bytes side by side with the widest checksum, then a
  // barcode abandoned part way by a rewrite of the register.
  task automatic test_encode_directed();
    set_mode(MODE_ENCODE);
    for (int i = 0; i < DATA_BYTES; i++) begin
      send_word(i[0] ? 8'hFF : 8'h00, (i == DATA_BYTES - 1) ? 4'hF : 4'h0);
    end
    send_word(8'hA5, 4'h0);
    send_word(8'h5A, 4'h0);
    send_word(8'hFF, 4'h0);
    set_mode(MODE_ENCODE);
  endtask

  // A clean barcode using the first and last characters of the alphabet, then the
  // null character and a character missing from the alphabet in a short barcode.
  task automatic test_decode_directed();
    set_mode(MODE_DECODE);
    send_word(glyphs[0], 4'h0);
    send_word(glyphs[63], 4'hF);
    for (int i = 2; i < SYMBOL_COUNT; i++) begin
      send_word(glyphs[$urandom_range(0, 63)], 4'h0);
    end
    send_word(glyphs[0], 4'h0);
    send_word(NUL_CHAR, 4'h0);
    send_word(CHAR_NOT_IN_SET, 4'h0);
    set_mode(MODE_DECODE);
  endtask

  task automatic test_encode_random();
    set_mode(MODE_ENCODE);
    for (int b = 0; b < 14; b++) begin
      calm = (b == 3 || b == 4);
      if (b == 6) begin
        // Abandon a barcode half way; the register write restarts the count.
        for (int i = 0; i < 3; i++) send_word(8'($urandom_range(0, 255)), 4'h0);
        set_mode(MODE_ENCODE);
      end
      if (b == 9) begin
        // Hold the sender until the block has caught up, in the middle of a barcode.
        for (int i = 0; i < 4; i++) send_word(8'($urandom_range(0, 255)), 4'h0);
        wait_idle();
        for (int i = 4; i < DATA_BYTES; i++) begin
          send_word(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
        end
      end else begin
        send_byte_barcode();
      end
    end
    calm = 1'b0;
  endtask

  task automatic test_decode_random();
    set_mode(MODE_DECODE);
    for (int b = 0; b < 14; b++) begin
      calm = (b == 5 || b == 6);
      if (b == 10) begin
        for (int i = 0; i < 5; i++) send_word(glyphs[$urandom_range(0, 63)], 4'h0);
        wait_idle();
        for (int i = 5; i < SYMBOL_COUNT; i++) send_word(glyphs[$urandom_range(0, 63)], 4'h0);
      end else begin
        send_text_barcode();
      end
    end
    calm = 1'b0;
  endtask

  // The direction flips between barcodes, sometimes with one left unfinished.
  task automatic test_direction_switching();
    logic dir;
    for (int k = 0; k < 4; k++) begin
      dir = k[0] ? MODE_ENCODE : MODE_DECODE;
      set_mode(dir);
      cfg_read_check(MODE_ADDR, {31'b0, dir});
      if (dir == MODE_ENCODE) send_byte_barcode();
      else send_text_barcode();
      if ($urandom_range(0, 1) == 1) begin
        for (int i = 0; i < 2; i++) send_word(8'($urandom_range(0, 255)), 4'h0);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 64; i++) glyphs[i] = ALPHABET[8*(63-i) +: 8];
    set_direction(MODE_ENCODE);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_mode_register();
    test_encode_directed();
    test_decode_directed();
    test_encode_random();
    test_decode_random();
    test_direction_switching();

    wait_idle();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
